// File: src/assert_macros.svh
// assertion macros shared by the histogram binning engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define HBE_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("hbe invariant violated");

// antecedent at one edge implies consequent at the next edge
`define HBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hbe sequence violated");

`endif

// File: src/hbe_pkg.sv
// shared types and constants of the histogram binning engine
`default_nettype none
package hbe_pkg;

    localparam int MAX_BINS    = 256;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int CNT_W       = 32;
    localparam int SAMPLE_W    = 16;
    localparam int SCALE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = SAMPLE_W + SCALE_W;
    localparam int BCNT_W      = 9;
    localparam int CMD_W       = 2;
    localparam int SEL_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_EDGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] LOWER_EDGE_RST = '0;
    localparam logic [SCALE_W-1:0]         BIN_SCALE_RST  = SCALE_W'(256);
    localparam logic [BCNT_W-1:0]          BIN_COUNT_RST  = BCNT_W'(MAX_BINS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [BIN_W-1:0] bin;
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } back_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// File: src/hbe_front.sv
// front end: configuration registers, input transfer and bin computation
`default_nettype none
module hbe_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [hbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [hbe_pkg::CMD_W-1:0]       cmd,
    input  wire logic signed [hbe_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [hbe_pkg::SEL_W-1:0]       bin_select,
    output logic                                 q_push,
    output hbe_pkg::op_t                         q_data,
    input  wire logic                            q_full
);
    import hbe_pkg::*;

    logic signed [SAMPLE_W-1:0] lower_edge_reg;
    logic [SCALE_W-1:0]         bin_scale_reg;
    logic [BCNT_W-1:0]          bin_count_reg;

    logic                s1_valid_reg;
    cmd_t                s1_cmd_reg;
    logic [SAMPLE_W-1:0] s1_diff_reg;
    logic [BIN_W-1:0]    s1_sel_reg;

    logic                s2_valid_reg;
    cmd_t                s2_cmd_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic [BIN_W-1:0]    s2_sel_reg;

    logic                    accept;
    logic                    s2_adv;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W-1:0]     diff_pos;
    logic [BCNT_W-1:0]       count_m1;
    logic [BIN_W-1:0]        last_bin;
    logic [CNT_W-1:0]        bin_full;
    logic [BIN_W-1:0]        bin_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_edge_reg <= LOWER_EDGE_RST;
            bin_scale_reg  <= BIN_SCALE_RST;
            bin_count_reg  <= BIN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOWER_EDGE: lower_edge_reg <= signed'(cfg_data[SAMPLE_W-1:0]);
                CFG_BIN_SCALE:  bin_scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_BIN_COUNT:  bin_count_reg  <= cfg_data[BCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // samples at or below the lower edge land in bin 0
    assign diff     = {sample[SAMPLE_W-1], sample}
                      - {lower_edge_reg[SAMPLE_W-1], lower_edge_reg};
    assign diff_pos = diff[SAMPLE_W] ? '0 : diff[SAMPLE_W-1:0];

    assign s2_adv = !s2_valid_reg || !q_full;
    assign full   = s1_valid_reg && !s2_adv;
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept || (s1_valid_reg && !s2_adv);
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_t'(cmd);
            s1_diff_reg <= diff_pos;
            s1_sel_reg  <= bin_select[BIN_W-1:0];
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_cmd_reg  <= s1_cmd_reg;
            s2_prod_reg <= PROD_W'(s1_diff_reg) * PROD_W'(bin_scale_reg);
            s2_sel_reg  <= s1_sel_reg;
        end
    end

    // last bin in use: a count of zero acts as one, above the store as the store
    always_comb
    begin
        count_m1 = bin_count_reg - BCNT_W'(1);
        if (bin_count_reg == '0)
        begin
            last_bin = '0;
        end
        else if (bin_count_reg > BCNT_W'(MAX_BINS))
        begin
            last_bin = BIN_W'(MAX_BINS - 1);
        end
        else
        begin
            last_bin = count_m1[BIN_W-1:0];
        end
    end

    assign bin_full    = s2_prod_reg[PROD_W-1:FRAC_W];
    assign bin_clamped = (bin_full > {{(CNT_W-BIN_W){1'b0}}, last_bin})
                         ? last_bin : bin_full[BIN_W-1:0];

    always_comb
    begin
        q_data.cmd = s2_cmd_reg;
        unique case (s2_cmd_reg)
            CMD_ADD:   q_data.bin = bin_clamped;
            CMD_READ:  q_data.bin = s2_sel_reg;
            CMD_CLEAR: q_data.bin = '0;
            CMD_NOP:   q_data.bin = '0;
        endcase
    end

    assign q_push = s2_valid_reg && !q_full;

endmodule
`default_nettype wire

// File: src/hbe_fifo.sv
// short command queue between front and back
`default_nettype none
module hbe_fifo (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire hbe_pkg::op_t data_in,
    output logic              full,
    input  wire logic         pop,
    output hbe_pkg::op_t      data_out,
    output logic              empty
);
    import hbe_pkg::*;
    `include "assert_macros.svh"

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    `HBE_ASSERT_ALWAYS(a_fifo_bound, count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
    `HBE_ASSERT_ALWAYS(a_fifo_no_underflow, !(pop && empty))

endmodule
`default_nettype wire

// File: src/hbe_back.sv
// back end: bin memory read-modify-write, counters and result register
`default_nettype none
module hbe_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hbe_pkg::op_t               q_data,
    input  wire logic                       q_empty,
    output logic                            q_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic [hbe_pkg::BIN_W-1:0]       bin_index,
    output logic [hbe_pkg::CNT_W-1:0]       bin_value,
    output logic [hbe_pkg::CNT_W-1:0]       total_samples,
    output logic [hbe_pkg::CNT_W-1:0]       peak_count
);
    import hbe_pkg::*;
    `include "assert_macros.svh"

    back_state_t          state_reg;
    back_state_t          state_next;
    op_t                  op_reg;
    logic [CNT_W-1:0]     bin_mem [MAX_BINS];
    logic [CNT_W-1:0]     rd_data_reg;
    logic [MAX_BINS-1:0]  valid_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     total_next;
    logic [CNT_W-1:0]     peak_reg;
    logic [CNT_W-1:0]     peak_next;
    logic                 res_valid_reg;
    logic [BIN_W-1:0]     res_idx_reg;
    logic [BIN_W-1:0]     res_idx_next;
    logic [CNT_W-1:0]     res_val_reg;
    logic [CNT_W-1:0]     res_val_next;
    logic [CNT_W-1:0]     old_count;
    logic [CNT_W-1:0]     new_count;
    logic                 finish;
    logic                 mem_we;

    // an entry not written since reset or clear reads as zero
    assign old_count = valid_reg[op_reg.bin] ? rd_data_reg : '0;
    assign new_count = sat_inc(old_count);
    assign mem_we    = finish && (op_reg.cmd == CMD_ADD);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!res_valid_reg || pop)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        res_idx_next = '0;
        res_val_next = '0;
        total_next   = total_reg;
        peak_next    = peak_reg;
        unique case (op_reg.cmd)
            CMD_ADD:
            begin
                res_idx_next = op_reg.bin;
                res_val_next = new_count;
                total_next   = sat_inc(total_reg);
                peak_next    = (new_count > peak_reg) ? new_count : peak_reg;
            end
            CMD_READ:
            begin
                res_idx_next = op_reg.bin;
                res_val_next = old_count;
            end
            CMD_CLEAR:
            begin
                total_next = '0;
                peak_next  = '0;
            end
            CMD_NOP:
            begin
                res_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[op_reg.bin] <= new_count;
        end
        if (q_pop)
        begin
            rd_data_reg <= bin_mem[q_data.bin];
            op_reg      <= q_data;
        end
        if (finish)
        begin
            res_idx_reg <= res_idx_next;
            res_val_reg <= res_val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            total_reg     <= '0;
            peak_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                total_reg     <= total_next;
                peak_reg      <= peak_next;
                res_valid_reg <= 1'b1;
                if (op_reg.cmd == CMD_CLEAR)
                begin
                    valid_reg <= '0;
                end
                else if (op_reg.cmd == CMD_ADD)
                begin
                    valid_reg[op_reg.bin] <= 1'b1;
                end
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign empty         = !res_valid_reg;
    assign bin_index     = res_idx_reg;
    assign bin_value     = res_val_reg;
    assign total_samples = total_reg;
    assign peak_count    = peak_reg;

    `HBE_ASSERT_NEXT(a_issue_then_exec, q_pop, state_reg == ST_EXEC)
    `HBE_ASSERT_ALWAYS(a_peak_le_total, peak_reg <= total_reg)
    `HBE_ASSERT_NEXT(a_add_marks_valid, mem_we, valid_reg[$past(op_reg.bin)])

endmodule
`default_nettype wire

// File: src/histogram_binning_engine_core.sv
// top level of the uniform-bin histogram engine
// usage:
//   commands enter through a queue-style port: a transfer happens at a rising
//   edge with push high and full low; cmd selects add (bin a sample), read
//   (report one bin), clear (zero all bins, total and peak) or no operation
//   results leave the same way: the oldest result sits on bin_index,
//   bin_value, total_samples and peak_count while empty is low, and a
//   transfer happens at a rising edge with pop high and empty low
//   configuration (lower edge, bin_scale, bin_count) is written through
//   cfg_we/cfg_index/cfg_data, one register per edge, only while idle
// timing:
//   a command passes the front stages and the queue, then the back end
//   takes it, reading the bin memory, and writes an add's new count back
//   as it finishes; the back end works on one command at a time
//   a 2-stage front (difference, then 16x32 multiply) feeds a 4-entry
//   command queue, so the front keeps taking commands while the back works
// reset and stalls:
//   rst_n clears control, counters, configuration and the per-bin valid bits
//   at once, so the bin store reads as zero with no clearing pass
//   when pop is held low the result register holds, the back stops, the
//   queue fills and full rises; nothing is dropped
`default_nettype none
module histogram_binning_engine_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [hbe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [hbe_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [hbe_pkg::CMD_W-1:0]          cmd,
    input  wire logic signed [hbe_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [hbe_pkg::SEL_W-1:0]          bin_select,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic [hbe_pkg::BIN_W-1:0]               bin_index,
    output logic [hbe_pkg::CNT_W-1:0]               bin_value,
    output logic [hbe_pkg::CNT_W-1:0]               total_samples,
    output logic [hbe_pkg::CNT_W-1:0]               peak_count
);
    import hbe_pkg::*;

    // front to queue
    op_t  fq_data;
    logic fq_push;
    logic fq_full;

    // queue to back
    op_t  qb_data;
    logic qb_pop;
    logic qb_empty;

    // front: config registers, input transfer, bin = clamp((diff*scale)>>16)
    hbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .sample     (sample),
        .bin_select (bin_select),
        .q_push     (fq_push),
        .q_data     (fq_data),
        .q_full     (fq_full)
    );

    // decoupling queue lets front and back stall independently
    hbe_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .data_in  (fq_data),
        .full     (fq_full),
        .pop      (qb_pop),
        .data_out (qb_data),
        .empty    (qb_empty)
    );

    // back: read-modify-write of the bin, saturating counters, result register
    hbe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (qb_data),
        .q_empty       (qb_empty),
        .q_pop         (qb_pop),
        .pop           (pop),
        .empty         (empty),
        .bin_index     (bin_index),
        .bin_value     (bin_value),
        .total_samples (total_samples),
        .peak_count    (peak_count)
    );

endmodule
`default_nettype wire

// File: sim/histogram_binning_engine_core_tb.sv
// self-checking testbench for the uniform-bin histogram engine
`timescale 1ns / 1ps

module histogram_binning_engine_core_tb;
    import hbe_pkg::*;

    // no transfer on either side for this many cycles ends the run; the
    // longest quiet stretch of a correct run is the forced receiver hold
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;

    // one result as it appears on the output ports
    typedef struct packed {
        logic [BIN_W-1:0] idx;
        logic [CNT_W-1:0] val;
        logic [CNT_W-1:0] tot;
        logic [CNT_W-1:0] peak;
    } outcome_t;

    // histogram predictor plus the queue of results it has promised
    class hist_scoreboard;
        logic [CNT_W-1:0]           counts [MAX_BINS];
        logic [CNT_W-1:0]           total;
        logic [CNT_W-1:0]           peak;
        logic signed [SAMPLE_W-1:0] lower_edge;
        logic [SCALE_W-1:0]         scale;
        logic [BCNT_W-1:0]          nbins;
        outcome_t                   awaited_q[$];
        int                         mismatches;
        int                         checked;

        function new();
            wipe();
            lower_edge = LOWER_EDGE_RST;
            scale      = BIN_SCALE_RST;
            nbins      = BIN_COUNT_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void wipe();
            foreach (counts[i])
                counts[i] = '0;
            total = '0;
            peak  = '0;
        endfunction

        function logic [CNT_W-1:0] step_count(logic [CNT_W-1:0] v);
            return (v == {CNT_W{1'b1}}) ? v : v + 1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_LOWER_EDGE: lower_edge = data[SAMPLE_W-1:0];
                CFG_BIN_SCALE:  scale      = data[SCALE_W-1:0];
                CFG_BIN_COUNT:  nbins      = data[BCNT_W-1:0];
                default: ;
            endcase
        endfunction

        // zero means one bin, anything past the store means the whole store
        function int active_bins();
            int n;
            n = nbins;
            if (n == 0)
                n = 1;
            if (n > MAX_BINS)
                n = MAX_BINS;
            return n;
        endfunction

        function void note_command(cmd_t op, logic signed [SAMPLE_W-1:0] s,
                                   logic [SEL_W-1:0] sel);
            outcome_t    exp;
            int          diff;
            logic [63:0] prod;
            logic [63:0] b;
            exp = '0;
            case (op)
                CMD_ADD:
                begin
                    // samples at or below the lower edge land in bin 0
                    diff = int'(s) - int'(lower_edge);
                    b = '0;
                    if (diff > 0)
                    begin
                        prod = {32'd0, diff[31:0]} * {32'd0, scale};
                        b = prod >> FRAC_W;
                    end
                    if (b > 64'(active_bins() - 1))
                        b = 64'(active_bins() - 1);
                    exp.idx = b[BIN_W-1:0];
                    counts[exp.idx] = step_count(counts[exp.idx]);
                    exp.val = counts[exp.idx];
                    total = step_count(total);
                    if (exp.val > peak)
                        peak = exp.val;
                end
                CMD_READ:
                begin
                    // bins past bin_count still report what they hold
                    exp.idx = sel;
                    exp.val = counts[sel];
                end
                CMD_CLEAR: wipe();
                default: ;
            endcase
            exp.tot  = total;
            exp.peak = peak;
            awaited_q.push_back(exp);
        endfunction

        function void check_result(outcome_t got);
            outcome_t exp;
            checked++;
            if (awaited_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing awaited: idx %0d val %0d tot %0d peak %0d",
                             $realtime, got.idx, got.val, got.tot, got.peak);
                return;
            end
            exp = awaited_q.pop_front();
            if (got.idx !== exp.idx || got.val !== exp.val ||
                got.tot !== exp.tot || got.peak !== exp.peak)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch on result %0d", $realtime, checked);
                    $display("    bin_index     exp %0d got %0d", exp.idx, got.idx);
                    $display("    bin_value     exp %0d got %0d", exp.val, got.val);
                    $display("    total_samples exp %0d got %0d", exp.tot, got.tot);
                    $display("    peak_count    exp %0d got %0d", exp.peak, got.peak);
                end
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       push;
    logic                       full;
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic [SEL_W-1:0]           bin_select;
    logic                       pop;
    logic                       empty;
    logic [BIN_W-1:0]           bin_index;
    logic [CNT_W-1:0]           bin_value;
    logic [CNT_W-1:0]           total_samples;
    logic [CNT_W-1:0]           peak_count;

    hist_scoreboard sb;

    // idling controls of the stimulus and the receiver, and the watchdog count
    bit tx_idle;
    bit rx_idle;
    bit hold_request;
    int hold_left;
    int quiet_cycles;

    // statistics for the closing summary
    int n_add;
    int n_read;
    int n_clear;
    int n_nop;
    int n_settings;

    histogram_binning_engine_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .sample        (sample),
        .bin_select    (bin_select),
        .pop           (pop),
        .empty         (empty),
        .bin_index     (bin_index),
        .bin_value     (bin_value),
        .total_samples (total_samples),
        .peak_count    (peak_count)
    );

    always #5 clk = ~clk;

    // mostly no gap, often a short one, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // receiver: pop changes on the falling edge; a hold request from the
    // stimulus keeps pop low for a long stretch so the input side backs up
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop = 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            pop = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pop = 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 99) < 25)
        begin
            hold_left = gap_len();
            pop = (hold_left == 0);
        end
        else
        begin
            pop = 1'b1;
        end
    end

    // result transfer: outputs taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result({bin_index, bin_value, total_samples, peak_count});
    end

    // watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.awaited_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one command transfer; entered and left at a falling edge, push stays
    // high across back-to-back commands
    task automatic send_command(cmd_t op, logic [SAMPLE_W-1:0] s, logic [SEL_W-1:0] sel);
        int gap;
        gap = tx_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push       = 1'b1;
        cmd        = op;
        sample     = s;
        bin_select = sel;
        do
            @(posedge clk);
        while (full);
        sb.note_command(op, s, sel);
        case (op)
            CMD_ADD:   n_add++;
            CMD_READ:  n_read++;
            CMD_CLEAR: n_clear++;
            default:   n_nop++;
        endcase
        @(negedge clk);
    endtask

    // let every awaited result come back, then let the pipe settle
    task automatic drain();
        push = 1'b0;
        while (sb.awaited_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(index, data);
    endtask

    // random traffic: mostly adds aimed into the active bin range, some
    // reads of in-range and out-of-range bins, no-ops and rare clears
    task automatic random_commands(int n);
        int          r;
        int          span;
        logic [63:0] wide;
        logic [15:0] s;
        logic [7:0]  sel;
        cmd_t        op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 999);
            if (r < 5)
                op = CMD_CLEAR;
            else if (r < 150)
                op = CMD_READ;
            else if (r < 230)
                op = CMD_NOP;
            else
                op = CMD_ADD;
            // sample span that covers every active bin
            if (sb.scale == 0)
            begin
                span = 65535;
            end
            else
            begin
                wide = (64'(sb.active_bins()) << FRAC_W) / sb.scale + 1;
                span = (wide > 64'd65535) ? 65535 : int'(wide);
            end
            if ($urandom_range(0, 99) < 65)
                s = sb.lower_edge + 16'($urandom_range(0, span));
            else
                s = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
                sel = 8'($urandom_range(0, sb.active_bins() - 1));
            else
                sel = 8'($urandom);
            send_command(op, s, sel);
        end
    endtask

    // one register setting followed by random traffic
    task automatic run_setting(logic [CFG_DATA_W-1:0] edge_data,
                               logic [CFG_DATA_W-1:0] scale_data,
                               logic [CFG_DATA_W-1:0] count_data,
                               int n, bit idle, bit pressure);
        drain();
        write_register(CFG_LOWER_EDGE, edge_data);
        write_register(CFG_BIN_SCALE, scale_data);
        write_register(CFG_BIN_COUNT, count_data);
        n_settings++;
        tx_idle = idle && !pressure;
        rx_idle = idle || pressure;
        if (pressure)
            hold_request = 1'b1;
        random_commands(n);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        push         = 1'b0;
        cmd          = CMD_NOP;
        sample       = '0;
        bin_select   = '0;
        pop          = 1'b0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        n_add        = 0;
        n_read       = 0;
        n_clear      = 0;
        n_nop        = 0;
        n_settings   = 1;
        sb = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset settings: 256 sample units per bin
        send_command(CMD_ADD, 16'h0000, 8'h00);    // on the lower edge
        send_command(CMD_ADD, 16'h8000, 8'h00);    // far below the lower edge
        send_command(CMD_ADD, 16'h7FFF, 8'h00);    // top of the sample range
        send_command(CMD_ADD, 16'h0100, 8'h00);    // first sample of bin 1
        send_command(CMD_ADD, 16'h00FF, 8'h00);    // last sample of bin 0
        send_command(CMD_ADD, 16'hFFFF, 8'h00);    // just below the edge
        // back-to-back adds to one bin exercise the read-modify-write order
        send_command(CMD_ADD, 16'h7FFF, 8'h00);
        send_command(CMD_ADD, 16'h7F80, 8'h00);
        send_command(CMD_READ, 16'h0000, 8'd127);
        send_command(CMD_READ, 16'hFFFF, 8'd0);
        send_command(CMD_READ, 16'h0000, 8'hFF);   // never written
        send_command(CMD_NOP, 16'h5555, 8'hAA);
        send_command(CMD_ADD, 16'h0001, 8'h00);
        send_command(CMD_ADD, 16'h0001, 8'h00);
        send_command(CMD_READ, 16'h0000, 8'd0);
        send_command(CMD_CLEAR, 16'hAAAA, 8'h55);
        send_command(CMD_READ, 16'h0000, 8'd0);
        send_command(CMD_READ, 16'h0000, 8'd127);
        send_command(CMD_NOP, 16'h0000, 8'h00);
        send_command(CMD_ADD, 16'h5555, 8'h00);
        send_command(CMD_ADD, 16'hAAAA, 8'h00);
        send_command(CMD_READ, 16'h0000, 8'd85);

        // widest scale from the lowest edge: everything above it clamps high
        run_setting(32'h0000_8000, 32'hFFFF_FFFF, 32'd256, 180, 1'b1, 1'b0);
        // zero scale, zero bins (one bin in use), highest edge, no idling
        run_setting(32'h0000_7FFF, 32'h0000_0000, 32'd0, 150, 1'b0, 1'b0);
        // eight narrow bins: deep counts and many adds to the same bin
        run_setting(32'h0000_FF9C, 32'h0000_1000, 32'd8, 300, 1'b1, 1'b0);
        // junk in the unused data bits, bin_count above the store size
        run_setting({16'($urandom), 16'h0000}, 32'h0001_0000,
                    {23'($urandom), 9'h1FF}, 220, 1'b1, 1'b0);
        run_setting(32'($urandom), 32'($urandom_range(1, 32'h0004_0000)),
                    32'($urandom_range(1, 256)), 260, 1'b1, 1'b0);
        // receiver holds off while the sender keeps offering
        run_setting(32'h0000_FC18, 32'h0000_0800, 32'd64, 260, 1'b1, 1'b1);
        // a single bin, one sample unit per bin, no idling
        run_setting(32'h0000_0000, 32'h0001_0000, 32'd1, 150, 1'b0, 1'b0);
        run_setting(32'($urandom), 32'($urandom), 32'd255, 200, 1'b1, 1'b0);

        drain();
        if (sb.awaited_q.size() != 0)
        begin
            $display("%0d results never arrived", sb.awaited_q.size());
            sb.mismatches++;
        end
        $display("run covered %0d commands (%0d adds, %0d reads, %0d clears, %0d no-ops)",
                 n_add + n_read + n_clear + n_nop, n_add, n_read, n_clear, n_nop);
        $display("over %0d register settings; %0d results checked, %0d mismatches",
                 n_settings, sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/hbe_pkg.sv
src/hbe_front.sv
src/hbe_fifo.sv
src/hbe_back.sv
src/histogram_binning_engine_core.sv
sim/histogram_binning_engine_core_tb.sv
